@@ sv/sbpt_pkg.sv @@
// shared constants, codes and control structs for the serial byte packetizer
// no dependencies; imported by every module of the block but sbpt_ram

package sbpt_pkg;

  localparam int MSG_BYTES = 32;
  localparam int ADDR_W = (MSG_BYTES > 1) ? $clog2(MSG_BYTES) : 1;
  localparam int FILL_W = $clog2(MSG_BYTES + 1);
  localparam int BYTE_W = 8;
  localparam int LEN_W = 7;
  localparam int TICK_W = 17;
  localparam int TIMEOUT_W = 16;
  localparam int CFG_DW = 32;
  localparam int CFG_AW = 3;

  localparam logic [TICK_W-1:0] TICK_MAX = {TICK_W{1'b1}};
  localparam logic [TIMEOUT_W-1:0] TIMEOUT_RST = 16'd31;
  localparam logic [BYTE_W-1:0] END_BYTE_RST = 8'h0D;

  // item kinds on the input tuser
  localparam logic CMD_BYTE = 1'b0;
  localparam logic CMD_TICK = 1'b1;

  // register index, taken from paddr[2]
  localparam logic REG_TIMEOUT = 1'b0;
  localparam logic REG_END_BYTE = 1'b1;

  // controller to datapath
  typedef struct packed {
    logic accept;   // input beat taken this cycle
    logic rd_en;    // read the next stored byte
    logic advance;  // output beat taken this cycle
  } sbpt_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic flush_go; // current input beat starts a non-empty flush
    logic last;     // byte on the output is the final one
  } sbpt_stat_t;

endpackage

@@ sv/sbpt_ram.sv @@
// generic single write port, single read port ram with registered read
// no dependencies

module sbpt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ sv/sbpt_ctrl.sv @@
// controller state machine: takes input beats and sequences the flush drain
// depends on sbpt_pkg

module sbpt_ctrl
  import sbpt_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  output logic       m_tvalid,
  input  logic       m_tready,
  input  sbpt_stat_t stat,
  output sbpt_cmd_t  cmd
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_SEND
  } state_t;

  state_t state;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      case (state)
        ST_IDLE: begin
          if (s_tvalid && stat.flush_go) begin
            state <= ST_READ;
          end
        end
        ST_READ: begin
          state <= ST_SEND;
        end
        ST_SEND: begin
          if (m_tready) begin
            state <= stat.last ? ST_IDLE : ST_READ;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  assign s_tready = (state == ST_IDLE);
  assign m_tvalid = (state == ST_SEND);

  always_comb begin
    cmd.accept = s_tvalid && s_tready;
    cmd.rd_en = (state == ST_READ);
    cmd.advance = m_tvalid && m_tready;
  end

endmodule

@@ sv/sbpt_dp.sv @@
// datapath: byte store, fill and tick counters, flush decision, read pointer
// depends on sbpt_pkg and sbpt_ram

module sbpt_dp
  import sbpt_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  sbpt_cmd_t            cmd,
  output sbpt_stat_t           stat,
  input  logic                 command,
  input  logic [BYTE_W-1:0]    rx_byte,
  input  logic [TIMEOUT_W-1:0] timeout_ticks,
  input  logic [BYTE_W-1:0]    end_byte,
  output logic [BYTE_W-1:0]    msg_byte,
  output logic [LEN_W-1:0]     msg_length
);

  logic [FILL_W-1:0] fill_count;
  logic [TICK_W-1:0] tick_count;
  logic [FILL_W-1:0] msg_len;
  logic [FILL_W-1:0] rd_cnt;

  logic              is_byte;
  logic              store_ok;
  logic [FILL_W-1:0] fill_after;
  logic [TICK_W-1:0] tick_after;
  logic              request;
  logic              flush;
  logic              go;
  logic [FILL_W:0]   rd_cnt_inc;

  always_comb begin
    is_byte = (command == CMD_BYTE);
    store_ok = (fill_count < FILL_W'(MSG_BYTES));
    fill_after = fill_count;
    tick_after = tick_count;
    request = 1'b0;
    if (is_byte) begin
      if (store_ok) begin
        fill_after = fill_count + FILL_W'(1);
      end
      request = (fill_after >= FILL_W'(MSG_BYTES)) || (rx_byte == end_byte);
    end else if (tick_count != TICK_MAX) begin
      tick_after = tick_count + TICK_W'(1);
    end
    flush = request || (tick_after > TICK_W'(timeout_ticks));
    go = flush && (fill_after != '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill_count <= '0;
      tick_count <= '0;
      msg_len <= '0;
      rd_cnt <= '0;
    end else begin
      if (cmd.accept) begin
        fill_count <= go ? '0 : fill_after;
        tick_count <= flush ? '0 : tick_after;
        if (go) begin
          msg_len <= fill_after;
          rd_cnt <= '0;
        end
      end
      if (cmd.advance) begin
        rd_cnt <= rd_cnt + FILL_W'(1);
      end
    end
  end

  sbpt_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (MSG_BYTES)
  ) u_store (
    .clk   (clk),
    .we    (cmd.accept && is_byte && store_ok),
    .waddr (fill_count[ADDR_W-1:0]),
    .wdata (rx_byte),
    .re    (cmd.rd_en),
    .raddr (rd_cnt[ADDR_W-1:0]),
    .rdata (msg_byte)
  );

  assign rd_cnt_inc = {1'b0, rd_cnt} + (FILL_W+1)'(1);

  always_comb begin
    stat.flush_go = go;
    stat.last = (rd_cnt_inc == {1'b0, msg_len});
  end

  assign msg_length = LEN_W'(msg_len);

endmodule

@@ sv/serial_byte_packetizer_timeout.sv @@
// top level of the serial byte packetizer: stream ports, register block
// depends on sbpt_pkg, sbpt_ctrl, sbpt_dp (and sbpt_ram through sbpt_dp)

// Collects received serial bytes into a 32-byte message store and sends them
// out as one message. An input beat is either a byte (tuser 0) or a timer tick
// (tuser 1). A message is flushed when the end byte arrives, when the store
// is full, or when the tick count exceeds timeout_ticks while bytes are
// pending; a flush clears the tick count, and a timeout with nothing stored
// only clears the tick count. Each message goes out one byte per beat, in
// arrival order, with tlast on the final byte and the message length beside
// every byte. An input beat that starts no flush leaves the input open; one
// that starts a flush keeps the input closed until the final byte is taken,
// output stalls included, and every byte is fetched from the store through
// its registered read port before it is shown. Registers: timeout_ticks at 0x0
// (reset 31), end_byte at 0x4 (reset 0x0D); write them only while idle.

module serial_byte_packetizer_timeout
  import sbpt_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  // input stream
  input  logic              s_tvalid,
  output logic              s_tready,
  input  logic [7:0]        s_tdata,   // [7:0] rx_byte
  input  logic              s_tuser,   // [0] command
  // output stream
  output logic              m_tvalid,
  input  logic              m_tready,
  output logic [15:0]       m_tdata,   // [7:0] msg_byte, [14:8] msg_length, [15] zero
  output logic              m_tlast,   // msg_last
  // register port
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [CFG_DW-1:0] pwdata,
  output logic [CFG_DW-1:0] prdata,
  output logic              pready
);

  logic [TIMEOUT_W-1:0] timeout_ticks;
  logic [BYTE_W-1:0]    end_byte;
  logic                 reg_wr;
  logic                 reg_sel;

  sbpt_cmd_t         cmd;
  sbpt_stat_t        stat;
  logic [BYTE_W-1:0] msg_byte;
  logic [LEN_W-1:0]  msg_length;

  // register block, zero wait states; address bit 2 picks the register
  assign pready = 1'b1;
  assign reg_wr = psel && penable && pwrite && pready;
  assign reg_sel = paddr[2];

  always_ff @(posedge clk) begin
    if (rst) begin
      timeout_ticks <= TIMEOUT_RST;
      end_byte <= END_BYTE_RST;
    end else if (reg_wr) begin
      case (reg_sel)
        REG_TIMEOUT: timeout_ticks <= pwdata[TIMEOUT_W-1:0];
        REG_END_BYTE: end_byte <= pwdata[BYTE_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_TIMEOUT: prdata = CFG_DW'(timeout_ticks);
      REG_END_BYTE: prdata = CFG_DW'(end_byte);
      default: prdata = '0;
    endcase
  end

  // controller: accepts beats, walks the store during a flush
  sbpt_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // datapath: counters, flush decision and byte store
  sbpt_dp u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .stat          (stat),
    .command       (s_tuser),
    .rx_byte       (s_tdata),
    .timeout_ticks (timeout_ticks),
    .end_byte      (end_byte),
    .msg_byte      (msg_byte),
    .msg_length    (msg_length)
  );

  // output beat packing
  assign m_tdata = {1'b0, msg_length, msg_byte};
  assign m_tlast = stat.last;

endmodule

@@ test/sbpt_msg_checker.sv @@
// message checker for the serial byte packetizer: predicts every output beat
// from the accepted input beats and register writes, and compares in order
// depends on sbpt_pkg

module sbpt_msg_checker
  import sbpt_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  input  logic              s_tready,
  input  logic [7:0]        s_tdata,   // [7:0] rx_byte
  input  logic              s_tuser,   // [0] command
  input  logic              m_tvalid,
  input  logic              m_tready,
  input  logic [15:0]       m_tdata,   // [7:0] msg_byte, [14:8] msg_length, [15] zero
  input  logic              m_tlast,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [CFG_DW-1:0] pwdata,
  input  logic              pready,
  output int                mismatches,
  output int                bytes_owed
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [BYTE_W-1:0] data;
    logic              last;
    logic [LEN_W-1:0]  len;
  } msg_beat_t;

  msg_beat_t owed_q[$];

  logic [BYTE_W-1:0]    held [MSG_BYTES];
  logic [LEN_W-1:0]     held_cnt;
  logic [TICK_W-1:0]    tick_cnt;
  logic [TIMEOUT_W-1:0] limit_ticks;
  logic [BYTE_W-1:0]    delim;
  int                   errs;

  // one accepted input beat: store the byte or count the tick, then flush
  task automatic take_item(input logic cmd, input logic [7:0] b);
    logic      flush_req;
    msg_beat_t e;
    flush_req = 1'b0;
    if (cmd == CMD_BYTE) begin
      if (held_cnt < MSG_BYTES) begin
        held[held_cnt] = b;
        held_cnt++;
      end
      flush_req = (held_cnt >= MSG_BYTES) || (b == delim);
    end else if (tick_cnt != TICK_MAX) begin
      tick_cnt++;
    end
    if (flush_req || tick_cnt > {1'b0, limit_ticks}) begin
      for (int k = 0; k < held_cnt; k++) begin
        e.data = held[k];
        e.last = (k + 1 == held_cnt);
        e.len  = held_cnt;
        owed_q.push_back(e);
      end
      held_cnt = '0;
      tick_cnt = '0;
    end
  endtask

  task automatic check_beat();
    msg_beat_t e;
    if (owed_q.size() == 0) begin
      $display("%0t: unexpected output beat, expected none, actual tdata %h tlast %b",
               $time, m_tdata, m_tlast);
      errs++;
    end else begin
      e = owed_q.pop_front();
      if (m_tdata[7:0] !== e.data) begin
        $display("%0t: msg_byte expected %h actual %h", $time, e.data, m_tdata[7:0]);
        errs++;
      end
      if (m_tdata[14:8] !== e.len) begin
        $display("%0t: msg_length expected %0d actual %0d", $time, e.len, m_tdata[14:8]);
        errs++;
      end
      if (m_tlast !== e.last) begin
        $display("%0t: msg_last expected %b actual %b", $time, e.last, m_tlast);
        errs++;
      end
      if (m_tdata[15] !== 1'b0) begin
        $display("%0t: tdata pad bit expected 0 actual %b", $time, m_tdata[15]);
        errs++;
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      owed_q.delete();
      held_cnt    = '0;
      tick_cnt    = '0;
      limit_ticks = TIMEOUT_RST;
      delim       = END_BYTE_RST;
      errs        = 0;
    end else begin
      // output first: a beat at this edge belongs to an earlier flush
      if (m_tvalid && m_tready) check_beat();
      if (s_tvalid && s_tready) take_item(s_tuser, s_tdata);
      if (psel && penable && pwrite && pready) begin
        if (paddr[2] == REG_TIMEOUT) limit_ticks = pwdata[TIMEOUT_W-1:0];
        else delim = pwdata[BYTE_W-1:0];
      end
    end
    mismatches <= errs;
    bytes_owed <= owed_q.size();
  end

endmodule

@@ test/tb_serial_byte_packetizer_timeout.sv @@
// top of the serial byte packetizer regression: clock, reset, stimulus and verdict
// depends on sbpt_pkg, serial_byte_packetizer_timeout and sbpt_msg_checker

module tb_serial_byte_packetizer_timeout;
  import sbpt_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              s_tvalid = 1'b0;
  logic              s_tready;
  logic [7:0]        s_tdata = '0;    // [7:0] rx_byte
  logic              s_tuser = 1'b0;  // [0] command
  logic              m_tvalid;
  logic              m_tready = 1'b0;
  logic [15:0]       m_tdata;         // [7:0] msg_byte, [14:8] msg_length, [15] zero
  logic              m_tlast;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [CFG_AW-1:0] paddr = '0;
  logic [CFG_DW-1:0] pwdata = '0;
  logic [CFG_DW-1:0] prdata;
  logic              pready;

  int                mismatches;
  int                bytes_owed;

  // stimulus side copy of the registers, only to shape the sequences
  logic [15:0]       cfg_timeout = TIMEOUT_RST;
  logic [7:0]        cfg_end = END_BYTE_RST;
  int                items_sent = 0;
  // phase with no idling on either side
  logic              no_gaps = 1'b0;
  // asks the receiver for one long hold-off
  logic              hold_req = 1'b0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  serial_byte_packetizer_timeout DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  sbpt_msg_checker u_checker (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tuser    (s_tuser),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tlast    (m_tlast),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .pready     (pready),
    .mismatches (mismatches),
    .bytes_owed (bytes_owed)
  );

  // offer one input beat after a random gap and hold it until taken
  task automatic send_item(input logic cmd, input logic [7:0] b);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 13);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= cmd;
    s_tdata  <= b;
    do @(posedge clk); while (!s_tready);
    items_sent++;
  endtask

  // random byte that is not the current delimiter
  function automatic logic [7:0] plain_byte();
    logic [7:0] b;
    b = 8'($urandom);
    if (b == cfg_end) b ^= 8'h01;
    return b;
  endfunction

  // stop offering, let every owed byte come out, then let the block settle
  // (the owed count of the last accepted beat is registered in the checker)
  task automatic wait_idle();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (bytes_owed != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  // setup phase, access phase until pready, then the bus released
  task automatic reg_write(input logic sel, input logic [31:0] v);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {sel, 2'b00};
    pwdata  <= v;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    if (sel == REG_TIMEOUT) cfg_timeout = v[15:0];
    else cfg_end = v[7:0];
  endtask

  task automatic set_phase(input logic [15:0] tmo, input logic [7:0] delim);
    wait_idle();
    reg_write(REG_TIMEOUT, {16'd0, tmo});
    reg_write(REG_END_BYTE, {24'd0, delim});
  endtask

  // mostly well-formed messages: delimited runs (some long enough to fill
  // the store), runs closed by ticks while the timeout is at most 16, and some loose beats as noise
  task automatic random_phase(input int quota);
    int start;
    int kind;
    int len;
    start = items_sent;
    while (items_sent - start < quota) begin
      kind = $urandom_range(0, 9);
      if (kind < 5) begin
        len = ($urandom_range(0, 7) == 0) ? $urandom_range(28, 40) : $urandom_range(0, 6);
        repeat (len) send_item(CMD_BYTE, plain_byte());
        send_item(CMD_BYTE, cfg_end);
      end else if (kind < 8) begin
        len = $urandom_range(1, 6);
        repeat (len) send_item(CMD_BYTE, plain_byte());
        if (cfg_timeout <= 16) repeat (int'(cfg_timeout) + 1) send_item(CMD_TICK, 8'($urandom));
        else send_item(CMD_BYTE, cfg_end);
      end else begin
        send_item(1'($urandom_range(0, 1)), 8'($urandom));
      end
    end
  endtask

  // receiver: random stall before every beat, one long hold-off on request
  initial begin
    int w;
    while (rst) @(posedge clk);
    forever begin
      if (hold_req) begin
        // long stretch: the block stalls on its output and closes its input
        m_tready <= 1'b0;
        hold_req <= 1'b0;
        repeat (400) @(posedge clk);
      end
      w = no_gaps ? 0 : $urandom_range(0, 13);
      if (w > 0) begin
        m_tready <= 1'b0;
        repeat (w) @(posedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
    end
  end

  // main sequence
  initial begin
    int guard;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: data extremes, then the delimiter at its reset value
    send_item(CMD_BYTE, 8'h00);
    send_item(CMD_BYTE, 8'hFF);
    send_item(CMD_BYTE, END_BYTE_RST);
    // tick with nothing stored only counts
    send_item(CMD_TICK, 8'hA5);

    // flush on timeout of a partial message
    set_phase(16'd1, END_BYTE_RST);
    send_item(CMD_BYTE, 8'h12);
    send_item(CMD_TICK, 8'h5A);
    send_item(CMD_TICK, 8'h00);

    // timeout lowered below the tick count: the next byte flushes
    set_phase(16'hFFFF, END_BYTE_RST);
    send_item(CMD_BYTE, 8'h34);
    send_item(CMD_TICK, 8'hFF);
    send_item(CMD_TICK, 8'h01);
    send_item(CMD_TICK, 8'h80);
    wait_idle();
    reg_write(REG_TIMEOUT, 32'd1);
    send_item(CMD_BYTE, 8'h56);

    // timeout of zero: every tick flushes whatever is pending
    set_phase(16'd0, END_BYTE_RST);
    send_item(CMD_BYTE, 8'h01);
    send_item(CMD_TICK, 8'hFE);
    send_item(CMD_TICK, 8'h7F);

    // delimiter at its extremes; carriage return is plain data then
    set_phase(16'hFFFF, 8'hFF);
    send_item(CMD_BYTE, END_BYTE_RST);
    send_item(CMD_BYTE, 8'hFF);
    wait_idle();
    reg_write(REG_END_BYTE, 32'd0);
    send_item(CMD_BYTE, 8'h7F);
    send_item(CMD_BYTE, 8'h00);

    // random phases over several register settings
    set_phase(16'd3, END_BYTE_RST);
    random_phase(45);

    set_phase(16'hFFFF, 8'hFF);
    hold_req <= 1'b1;
    random_phase(40);

    set_phase(16'd0, 8'h00);
    no_gaps = 1'b1;
    random_phase(40);
    wait_idle();
    no_gaps = 1'b0;

    set_phase(16'($urandom_range(1, 8)), 8'($urandom));
    random_phase(45);

    set_phase(16'd12, END_BYTE_RST);
    random_phase(40);

    set_phase(16'd1, 8'($urandom));
    random_phase(40);

    // drain and let the block settle before the verdict
    s_tvalid <= 1'b0;
    @(posedge clk);
    guard = 0;
    while (bytes_owed != 0 && guard < 50000) begin
      @(posedge clk);
      guard++;
    end
    repeat (40) @(posedge clk);
    if (mismatches == 0 && bytes_owed == 0) begin
      $display("serial_byte_packetizer_timeout regression: pass");
    end else begin
      $display("serial_byte_packetizer_timeout regression: fail");
    end
    $finish;
  end

  // watchdog, far beyond the slowest correct run
  initial begin
    #8000000;
    $display("serial_byte_packetizer_timeout regression: fail");
    $finish;
  end

endmodule
